[src/c3g_pkg.sv]
// Shared types and constants of the 3x3 grayscale convolution unit.
// Used by the tap cells, the line buffer and the top level; depends on nothing.
package c3g_pkg;

    // Pixel width of source and result words.
    localparam int PIX_W = 8;

    // Row counter width: one bit above the 16-bit frame height so that the
    // flush row after a frame of the largest height can still be counted.
    localparam int ROW_W = 17;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int FW_W       = 11;
    localparam int FH_W       = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_MID    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd4;

    // Control of one window tap cell.
    typedef struct packed {
        logic shift_en;    // load the tap from the right-hand neighbor
        logic capture_en;  // register the product of the new tap
    } cell_ctrl_t;

    // Control of the line buffer.
    typedef struct packed {
        logic rd_en;       // read the column of a newly accepted word
        logic wr_en;       // write back the column of the word in flight
    } lb_ctrl_t;

endpackage

[src/c3g_tap_cell.sv]
// One tap of the 3x3 window: a pixel register that takes its neighbor's value
// on every shift, and a registered product with its coefficient. Uses c3g_pkg.
module c3g_tap_cell #(
    parameter int COEF_BITS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  c3g_pkg::cell_ctrl_t               ctrl,
    input  logic [c3g_pkg::PIX_W-1:0]         tap_in,
    input  logic signed [COEF_BITS-1:0]       coef,
    output logic [c3g_pkg::PIX_W-1:0]         tap_out,
    output logic signed [COEF_BITS+c3g_pkg::PIX_W:0] prod_out
);

    localparam int PW = COEF_BITS + c3g_pkg::PIX_W + 1;

    logic [c3g_pkg::PIX_W-1:0] tap_reg;
    logic [c3g_pkg::PIX_W-1:0] tap_next;
    logic signed [PW-1:0]      prod_reg;
    logic signed [PW-1:0]      prod_next;

    // The tap moves one place left on each shift.
    always_comb begin
        tap_next = ctrl.shift_en ? tap_in : tap_reg;
    end

    // The product is formed from the value that the tap is about to take.
    always_comb begin
        prod_next = prod_reg;
        if (ctrl.capture_en) begin
            prod_next = PW'($signed({1'b0, tap_in}) * coef);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_reg <= '0;
        end else begin
            tap_reg <= tap_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign tap_out  = tap_reg;
    assign prod_out = prod_reg;

endmodule

[src/c3g_line_buf.sv]
// Two line stores holding the two previous image rows, with a bypass for a
// read that hits the column being written back. Uses c3g_pkg.
module c3g_line_buf #(
    parameter int MAX_LINE = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  c3g_pkg::lb_ctrl_t             ctrl,
    input  logic [$clog2(MAX_LINE)-1:0]   rd_addr,
    input  logic [$clog2(MAX_LINE)-1:0]   wr_addr,
    input  logic [c3g_pkg::PIX_W-1:0]     wr_pix,
    output logic [c3g_pkg::PIX_W-1:0]     upper_q,
    output logic [c3g_pkg::PIX_W-1:0]     lower_q
);

    logic [c3g_pkg::PIX_W-1:0] upper_mem [MAX_LINE];
    logic [c3g_pkg::PIX_W-1:0] lower_mem [MAX_LINE];

    logic [c3g_pkg::PIX_W-1:0] upper_rd_reg;
    logic [c3g_pkg::PIX_W-1:0] lower_rd_reg;
    logic                      fwd_reg;
    logic                      fwd_next;
    logic [c3g_pkg::PIX_W-1:0] fwd_upper_reg;
    logic [c3g_pkg::PIX_W-1:0] fwd_lower_reg;

    // A read that lands on the column written in the same cycle takes the
    // new values instead of the stale memory contents.
    always_comb begin
        fwd_next = fwd_reg;
        if (ctrl.rd_en) begin
            fwd_next = ctrl.wr_en && (wr_addr == rd_addr);
        end
    end

    // Memory write: the lower row moves up, the new pixel enters the lower row.
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            upper_mem[wr_addr] <= lower_q;
            lower_mem[wr_addr] <= wr_pix;
        end
    end

    // Registered memory read and the bypass data beside it.
    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            upper_rd_reg  <= upper_mem[rd_addr];
            lower_rd_reg  <= lower_mem[rd_addr];
            fwd_upper_reg <= lower_q;
            fwd_lower_reg <= wr_pix;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else begin
            fwd_reg <= fwd_next;
        end
    end

    assign upper_q = fwd_reg ? fwd_upper_reg : upper_rd_reg;
    assign lower_q = fwd_reg ? fwd_lower_reg : lower_rd_reg;

endmodule

[src/conv3x3_gray_clamp_unit.sv]
// Top level of the 3x3 grayscale convolution unit with clamped output.
// Instantiates c3g_line_buf and a 3x3 array of c3g_tap_cell; uses c3g_pkg.
//
// Usage: 8-bit pixels enter on the s_ channel in raster order, one word per
// accepted handshake; s_tuser high marks a drain word that counts as a zero
// pixel. Each word at frame position p yields the result for pixel
// p - width - 1, so after the last pixel of a frame the source sends
// width + 1 drain words. Results leave on the m_ channel; m_tlast marks the
// last result of a frame. Interior pixels get the nine-tap weighted sum
// clamped to 0..255, border pixels pass through unchanged.
// Throughput is one word per clock while the m_ side is not stalled. For
// the word that releases a result, the line store is read at the
// accepting edge, then the taps shift with the nine products registered in
// the cells, then the adder tree and clamp load the output register.
// A stalled m_ side holds its word in the output register while the
// inner stages keep filling; s_tready drops only when every stage is full.
// Reset (aresetn low, synchronous) empties the pipeline, restarts the frame
// position and loads the default registers (identity mask, 640 x 480).
// The user writes configuration words through cfg_we, cfg_index and
// cfg_wdata only while the block is idle; the block does not enforce it.
module conv3x3_gray_clamp_unit #(
    parameter int MAX_LINE  = 1024,
    parameter int COEF_BITS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] pixel_in
    input  logic                              s_tuser,   // [0] drain
    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [7:0] pixel_out
    output logic                              m_tlast,   // frame_end
    // Configuration write port.
    input  logic                              cfg_we,
    input  logic [c3g_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [c3g_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int PIX_W = c3g_pkg::PIX_W;
    localparam int ROW_W = c3g_pkg::ROW_W;
    localparam int FH_W  = c3g_pkg::FH_W;
    localparam int CW    = $clog2(MAX_LINE);
    localparam int XW    = $clog2(MAX_LINE + 1) + 1;
    localparam int PW    = COEF_BITS + PIX_W + 1;
    localparam int SW    = PW + 4;
    localparam int EXT_W = 3 * COEF_BITS + c3g_pkg::CFG_DATA_W;

    // Configuration registers.
    logic [c3g_pkg::CFG_DATA_W-1:0] coef_top_reg;
    logic [c3g_pkg::CFG_DATA_W-1:0] coef_mid_reg;
    logic [c3g_pkg::CFG_DATA_W-1:0] coef_bot_reg;
    logic [c3g_pkg::FW_W-1:0]       frame_width_reg;
    logic [FH_W-1:0]                frame_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_top_reg     <= 24'd0;
            coef_mid_reg     <= 24'd256;
            coef_bot_reg     <= 24'd0;
            frame_width_reg  <= 11'd640;
            frame_height_reg <= 16'd480;
        end else if (cfg_we) begin
            case (cfg_index)
                c3g_pkg::REG_COEF_TOP:     coef_top_reg     <= cfg_wdata;
                c3g_pkg::REG_COEF_MID:     coef_mid_reg     <= cfg_wdata;
                c3g_pkg::REG_COEF_BOTTOM:  coef_bot_reg     <= cfg_wdata;
                c3g_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[c3g_pkg::FW_W-1:0];
                c3g_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // Coefficients: field n of each row register, bits above bit 23 read as zero.
    logic [EXT_W-1:0]               coef_ext [3];
    logic signed [COEF_BITS-1:0]    coef [3][3];

    always_comb begin
        coef_ext[0] = {{(3 * COEF_BITS){1'b0}}, coef_top_reg};
        coef_ext[1] = {{(3 * COEF_BITS){1'b0}}, coef_mid_reg};
        coef_ext[2] = {{(3 * COEF_BITS){1'b0}}, coef_bot_reg};
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                coef[a][b] = $signed(coef_ext[a][b * COEF_BITS +: COEF_BITS]);
            end
        end
    end

    // Effective frame geometry.
    logic [31:0]      fw_wide;
    logic [XW-1:0]    w_eff;
    logic [FH_W-1:0]  h_eff;
    logic [ROW_W-1:0] h_ext;

    always_comb begin
        fw_wide = 32'(frame_width_reg);
        if (fw_wide < 32'd3) begin
            w_eff = XW'(3);
        end else if (fw_wide > 32'(MAX_LINE)) begin
            w_eff = XW'(MAX_LINE);
        end else begin
            w_eff = XW'(fw_wide);
        end
        h_eff = (frame_height_reg < 16'd3) ? 16'd3 : frame_height_reg;
        h_ext = {1'b0, h_eff};
    end

    // Handshake and stage valid signals.
    logic s_fire;
    logic st1_fire;
    logic st2_fire;
    logic st2_ready;
    logic out_ready;

    logic st1_valid_reg, st1_valid_next;
    logic st2_valid_reg, st2_valid_next;
    logic m_tvalid_reg,  m_tvalid_next;

    // Frame position counters.
    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // Position bookkeeping of the accepted word.
    logic             restart;
    logic [XW-1:0]    c_cur;
    logic [ROW_W-1:0] r_cur;
    logic             emit;
    logic [ROW_W-1:0] qr;
    logic [XW-1:0]    qc;
    logic             interior;
    logic             last_px;
    logic [XW-1:0]    c_inc;
    logic [PIX_W-1:0] px;

    always_comb begin
        restart = (XW'(col_reg) >= w_eff) || (row_reg > h_ext + 17'd1);
        c_cur   = restart ? '0 : XW'(col_reg);
        r_cur   = restart ? '0 : row_reg;
        emit    = (r_cur >= 17'd2) || ((r_cur == 17'd1) && (c_cur != '0));
        if (c_cur != '0) begin
            qr = r_cur - 17'd1;
            qc = c_cur - XW'(1);
        end else begin
            qr = r_cur - 17'd2;
            qc = w_eff - XW'(1);
        end
        interior = (qr != '0) && ((qr + 17'd2) <= h_ext)
                && (qc != '0) && ((qc + XW'(2)) <= w_eff);
        last_px  = emit && (qr == h_ext - 17'd1) && (qc == w_eff - XW'(1));
        px       = s_tuser ? '0 : s_tdata;

        // Next position; the last result of a frame starts a new one.
        c_inc    = c_cur + XW'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (s_fire) begin
            if (last_px) begin
                col_next = '0;
                row_next = '0;
            end else if (c_inc >= w_eff) begin
                col_next = '0;
                row_next = r_cur + 17'd1;
            end else begin
                col_next = c_inc[CW-1:0];
                row_next = r_cur;
            end
        end
    end

    // Stage one holds the word while its column is read from the line stores.
    logic [CW-1:0]    st1_col_reg;
    logic [PIX_W-1:0] st1_px_reg;
    logic             st1_emit_reg;
    logic             st1_int_reg;
    logic             st1_last_reg;

    // Stage two holds the result in flight while the cells hold its products.
    logic             st2_int_reg;
    logic             st2_last_reg;
    logic [PIX_W-1:0] st2_centre_reg;

    // Elastic pipeline control: each stage moves when the next one is free.
    always_comb begin
        out_ready = !m_tvalid_reg || m_tready;
        st2_fire  = st2_valid_reg && out_ready;
        st2_ready = !st2_valid_reg || out_ready;
        st1_fire  = st1_valid_reg && (!st1_emit_reg || st2_ready);
        s_tready  = !st1_valid_reg || st1_fire;
        s_fire    = s_tvalid && s_tready;

        st1_valid_next = s_fire ? 1'b1 : (st1_fire ? 1'b0 : st1_valid_reg);
        st2_valid_next = st2_valid_reg;
        if (st1_fire && st1_emit_reg) begin
            st2_valid_next = 1'b1;
        end else if (st2_fire) begin
            st2_valid_next = 1'b0;
        end
        m_tvalid_next = st2_fire ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
        end else begin
            st1_valid_reg <= st1_valid_next;
            st2_valid_reg <= st2_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            st1_col_reg  <= c_cur[CW-1:0];
            st1_px_reg   <= px;
            st1_emit_reg <= emit;
            st1_int_reg  <= interior;
            st1_last_reg <= last_px;
        end
    end

    // Line stores.
    c3g_pkg::lb_ctrl_t lb_ctrl;
    logic [PIX_W-1:0]  upper_q;
    logic [PIX_W-1:0]  lower_q;

    assign lb_ctrl.rd_en = s_fire;
    assign lb_ctrl.wr_en = st1_fire;

    c3g_line_buf #(
        .MAX_LINE(MAX_LINE)
    ) u_line_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (lb_ctrl),
        .rd_addr (c_cur[CW-1:0]),
        .wr_addr (st1_col_reg),
        .wr_pix  (st1_px_reg),
        .upper_q (upper_q),
        .lower_q (lower_q)
    );

    // Window: three rows of three cells, the new column enters at the right.
    c3g_pkg::cell_ctrl_t   cell_ctrl;
    logic [PIX_W-1:0]      col_in [3];
    logic [PIX_W-1:0]      tap_q  [3][3];
    logic signed [PW-1:0]  prod   [3][3];

    assign cell_ctrl.shift_en   = st1_fire;
    assign cell_ctrl.capture_en = st1_fire && st1_emit_reg;
    assign col_in[0] = upper_q;
    assign col_in[1] = lower_q;
    assign col_in[2] = st1_px_reg;

    for (genvar a = 0; a < 3; a++) begin : g_row
        for (genvar b = 0; b < 3; b++) begin : g_tap
            logic [PIX_W-1:0] tap_src;
            if (b == 2) begin : g_edge
                assign tap_src = col_in[a];
            end else begin : g_inner
                assign tap_src = tap_q[a][b + 1];
            end
            c3g_tap_cell #(
                .COEF_BITS(COEF_BITS)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (cell_ctrl),
                .tap_in   (tap_src),
                .coef     (coef[a][b]),
                .tap_out  (tap_q[a][b]),
                .prod_out (prod[a][b])
            );
        end
    end

    // The centre pixel of the due result is the middle tap before the shift.
    always_ff @(posedge aclk) begin
        if (st1_fire && st1_emit_reg) begin
            st2_int_reg    <= st1_int_reg;
            st2_last_reg   <= st1_last_reg;
            st2_centre_reg <= tap_q[1][2];
        end
    end

    // Sum of the nine products and clamp to the pixel range.
    logic signed [SW-1:0] sum;
    logic [PIX_W-1:0]     clamped;

    always_comb begin
        sum = '0;
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                sum = sum + SW'(prod[a][b]);
            end
        end
        if (sum < 0) begin
            clamped = '0;
        end else if (sum > SW'(255)) begin
            clamped = 8'd255;
        end else begin
            clamped = sum[PIX_W-1:0];
        end
    end

    // Output register.
    logic [PIX_W-1:0] m_tdata_reg;
    logic             m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (st2_fire) begin
            m_tdata_reg <= st2_int_reg ? clamped : st2_centre_reg;
            m_tlast_reg <= st2_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
